// ----- rtl/core/rsd_pkg.sv -----
// ============================================================================
// rsd_pkg : shared types and constants for the rating sort core
// Entry layout, compare result bundle and sequencer states.
// ============================================================================
package rsd_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int RATING_W        = 16;
  localparam int POS_W           = 6;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;

  // One stored entry: rating and its load position
  typedef struct packed {
    logic [RATING_W-1:0] rating;
    logic [POS_W-1:0]    pos;
  } entry_t;

  // Compare-and-select result
  typedef struct packed {
    entry_t wr_entry;    // higher of the two, goes to the lower address
    entry_t keep_entry;  // lower of the two, carried on down the pass
    logic   swap;        // carried entry rated strictly below the fetched one
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_P_RD0,
    ST_P_CUR,
    ST_P_CMP,
    ST_P_END,
    ST_E_RD,
    ST_E_OUT
  } state_t;

endpackage

// ----- rtl/core/rsd_store.sv -----
// ============================================================================
// rsd_store : entry memory
// One write port, one read port with registered read data.
// ============================================================================
module rsd_store #(
  parameter int DEPTH = rsd_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rsd_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output rsd_pkg::entry_t rd_data
);

  rsd_pkg::entry_t mem [DEPTH];
  rsd_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/rsd_cmp_unit.sv -----
// ============================================================================
// rsd_cmp_unit : compare-and-select step of a bubble pass
// Higher rating is written back; strict compare keeps equal ratings in order.
// ============================================================================
module rsd_cmp_unit (
  input  rsd_pkg::entry_t   carried,
  input  rsd_pkg::entry_t   fetched,
  output rsd_pkg::cmp_res_t res
);

  always_comb begin
    res.swap       = (carried.rating < fetched.rating);
    res.wr_entry   = res.swap ? fetched : carried;
    res.keep_entry = res.swap ? carried : fetched;
  end

endmodule

// ----- rtl/core/rating_sort_descending_core.sv -----
// ============================================================================
// rating_sort_descending_core : batch descending sort of player ratings
// Loads a batch of ratings, bubble-sorts it in place, streams it out.
// ============================================================================
//
//  Channel | Dir | Handshake           | Content
//  --------+-----+---------------------+--------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata: rating; tlast: batch end
//  out_    | out | out_tvalid/tready   | tdata: rating, load position;
//          |     |                     | tlast: final rank
//
//  Load: one request per cycle. Sort of N entries: bubble passes repeat
//    until one makes no swap (at most N passes). Emit: each result is read,
//    then placed in the output register once it is free. Sort passes run
//    through the single memory read port and the one shared compare unit.
//  in_tready is high only while loading; during sort and emit no request is
//    taken. The last result sits in the output register while loading resumes.
//  Reset (rst_n low, synchronous) clears sequencer, count and output valid;
//    memory contents need no clearing, only entries of the current batch
//    are ever read.
//  Requests beyond MAX_ENTRIES are dropped; a dropped one marked last still
//    closes the batch.
//
module rating_sort_descending_core #(
  parameter int MAX_ENTRIES = rsd_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rsd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] rating
  input  logic                             in_tlast,   // batch end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rsd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [15:0] sorted_rating,
                                                       // [21:16] entry_position,
                                                       // [23:22] zero
  output logic                             out_tlast   // final rank
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  rsd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;       // entries stored this batch
  logic [AW-1:0]   idx_r, idx_nxt;           // pass / emit index
  rsd_pkg::entry_t cur_r, cur_nxt;           // entry carried down a pass
  logic            swapped_r, swapped_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [rsd_pkg::RATING_W-1:0] out_rating_r, out_rating_nxt;
  logic [rsd_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic                         out_last_r, out_last_nxt;

  // memory port controls
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rsd_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  rsd_pkg::entry_t rd_data;

  rsd_pkg::cmp_res_t cmp_res;

  logic            in_req;
  logic [CW-1:0]   count_inc;
  logic            idx_at_end;
  logic            out_free;

  rsd_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared compare: carried entry against the one just fetched
  rsd_cmp_unit u_cmp (
    .carried (cur_r),
    .fetched (rd_data),
    .res     (cmp_res)
  );

  assign in_req     = in_tvalid && in_tready;
  assign idx_at_end = (CW'(idx_r) == count_r - 1'b1);
  assign out_free   = !out_valid_r || out_tready;

  // count after a possible store (capped)
  always_comb begin
    if (count_r < CW'(MAX_ENTRIES)) begin
      count_inc = count_r + 1'b1;
    end else begin
      count_inc = count_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    swapped_nxt    = swapped_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_rating_nxt = out_rating_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = cur_r;
    rd_addr        = idx_r;
    in_tready      = 1'b0;

    case (state_r)
      rsd_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_req) begin
          if (count_r < CW'(MAX_ENTRIES)) begin
            wr_en          = 1'b1;
            wr_addr        = count_r[AW-1:0];
            wr_data.rating = in_tdata[rsd_pkg::RATING_W-1:0];
            wr_data.pos    = rsd_pkg::POS_W'(count_r);
          end
          count_nxt = count_inc;
          if (in_tlast) begin
            idx_nxt = '0;
            if (count_inc > CW'(1)) begin
              state_nxt = rsd_pkg::ST_P_RD0;
            end else begin
              state_nxt = rsd_pkg::ST_E_RD;
            end
          end
        end
      end

      rsd_pkg::ST_P_RD0: begin
        rd_addr     = '0;
        swapped_nxt = 1'b0;
        state_nxt   = rsd_pkg::ST_P_CUR;
      end

      rsd_pkg::ST_P_CUR: begin
        cur_nxt   = rd_data;
        rd_addr   = AW'(1);
        idx_nxt   = AW'(1);
        state_nxt = rsd_pkg::ST_P_CMP;
      end

      rsd_pkg::ST_P_CMP: begin
        // rd_data holds entry idx; the winner settles at idx-1
        wr_en   = 1'b1;
        wr_addr = idx_r - 1'b1;
        wr_data = cmp_res.wr_entry;
        cur_nxt = cmp_res.keep_entry;
        if (cmp_res.swap) begin
          swapped_nxt = 1'b1;
        end
        if (idx_at_end) begin
          state_nxt = rsd_pkg::ST_P_END;
        end else begin
          rd_addr = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      rsd_pkg::ST_P_END: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = cur_r;
        if (swapped_r) begin
          state_nxt = rsd_pkg::ST_P_RD0;
        end else begin
          idx_nxt   = '0;
          state_nxt = rsd_pkg::ST_E_RD;
        end
      end

      rsd_pkg::ST_E_RD: begin
        state_nxt = rsd_pkg::ST_E_OUT;
      end

      rsd_pkg::ST_E_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rating_nxt = rd_data.rating;
          out_pos_nxt    = rd_data.pos;
          out_last_nxt   = idx_at_end;
          if (idx_at_end) begin
            count_nxt = '0;
            state_nxt = rsd_pkg::ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = rsd_pkg::ST_E_RD;
          end
        end
      end

      default: begin
        state_nxt = rsd_pkg::ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsd_pkg::ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    out_rating_r <= out_rating_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rsd_pkg::OUT_TDATA_W - rsd_pkg::RATING_W - rsd_pkg::POS_W){1'b0}},
                       out_pos_r, out_rating_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/rsd_checker.sv -----
// ============================================================================
// rsd_checker : port-level checks for the rating sort core
// Watches both stream channels; attached to the top level by bind.
// ============================================================================
module rsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rsd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // closing request stops further loading
  a_close_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after batch close");

  // non-closing request keeps the block loading
  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input ready dropped mid batch");

  // non-final result pending: no loading meanwhile
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready during emit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind rating_sort_descending_core rsd_checker u_rsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb.sv -----
// ============================================================================
// tb : self-checking bench for rating_sort_descending_core
// Loads batches of ratings over the input stream and checks each sorted
// result against an in-bench predictor of the stable descending sort.
// Covers a directed table, random batches, an over-capacity batch and
// random back-pressure on the output stream and random idle gaps on the input.
// ============================================================================
module tb;

  localparam int MAX_ENTRIES  = rsd_pkg::MAX_ENTRIES_DEF;
  localparam int RATING_W     = rsd_pkg::RATING_W;
  localparam int POS_W        = rsd_pkg::POS_W;
  localparam int IN_TDATA_W   = rsd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = rsd_pkg::OUT_TDATA_W;
  localparam int RAND_ITEMS   = 100;      // random requests to send
  localparam int OVERFLOW_AT  = 30;       // random request count that opens the big batch
  localparam int CALM_FROM    = 80;       // no idling on either side from here on
  localparam int TAIL_CYCLES  = 300;      // settle time once nothing is outstanding
  localparam int LIMIT_CYCLES = 400000;   // hard stop
  localparam int MAX_REPORTS  = 20;       // mismatch lines printed at most

  // Rating draw styles for random batches
  localparam int MODE_WIDE  = 0;          // anything in 0..65535
  localparam int MODE_TIES  = 1;          // tiny range, lots of equal ratings
  localparam int MODE_EDGES = 2;          // only the corner values

  // One sorted result as seen on the output stream
  typedef struct packed {
    logic [RATING_W-1:0] rating;
    logic [POS_W-1:0]    pos;
    logic                last;
  } ranked_t;

  // Directed row: request plus an optional hand-written result
  typedef struct packed {
    logic [RATING_W-1:0] rating;
    logic                last;
    logic                typed;
    ranked_t             res;
  } dir_row_t;

  localparam int DIR_ROWS = 19;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [15:0] rating
  logic                   in_tlast;    // batch end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [15:0] sorted_rating, [21:16] entry_position,
                                       // [23:22] zero
  logic                   out_tlast;   // final rank

  // Predictor state: the batch as loaded so far
  logic [RATING_W-1:0] batch_rating [MAX_ENTRIES];
  logic [POS_W-1:0]    batch_pos    [MAX_ENTRIES];
  int                  batch_len;

  ranked_t  ranked_q [$];              // sorted results still to arrive
  dir_row_t dir_tab  [DIR_ROWS];

  int  err_cnt = 0;
  int  cyc = 0;
  int  items_sent;
  int  results_seen = 0;
  int  batches_closed;
  int  hold_cnt = 0;
  bit  calm;

  rating_sort_descending_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Clock, cycle count and watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, ranked_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: store the request, and on batch end sort and queue results.
  // Insertion sort that only moves past strictly smaller ratings, so equal
  // ratings keep load order (same outcome as the block's bubble passes).
  // Requests past capacity are dropped but a dropped batch end still closes.
  // --------------------------------------------------------------------------
  task automatic take_rating(input logic [RATING_W-1:0] r, input logic last,
                             input logic typed, input ranked_t typed_res);
    logic [RATING_W-1:0] kr;
    logic [POS_W-1:0]    kp;
    int i;
    int j;
    int k;
    if (batch_len < MAX_ENTRIES) begin
      batch_rating[batch_len] = r;
      batch_pos[batch_len]    = POS_W'(batch_len);
      batch_len++;
    end
    if (last) begin
      for (i = 1; i < batch_len; i++) begin
        kr = batch_rating[i];
        kp = batch_pos[i];
        j  = i - 1;
        while (j >= 0 && batch_rating[j] < kr) begin
          batch_rating[j+1] = batch_rating[j];
          batch_pos[j+1]    = batch_pos[j];
          j--;
        end
        batch_rating[j+1] = kr;
        batch_pos[j+1]    = kp;
      end
      if (typed) begin
        ranked_q.push_back(typed_res);
      end else begin
        for (k = 0; k < batch_len; k++)
          ranked_q.push_back(ranked_t'{batch_rating[k], batch_pos[k], (k == batch_len - 1)});
      end
      batch_len = 0;
      batches_closed++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side. Called at a rising edge; drives the request, waits for the
  // handshake and returns at the edge that took it. Optional idle burst first,
  // with junk on the data lines to show they are ignored while tvalid is low.
  // --------------------------------------------------------------------------
  task automatic send_rating(input logic [RATING_W-1:0] r, input logic last,
                             input logic typed, input ranked_t typed_res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_rating(r, last, typed, typed_res);
    items_sent++;
  endtask

  // Sender holds off until every queued result has been seen
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random ready runs and stall bursts, steady ready once the
  // run goes calm.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
      hold_cnt   <= calm ? 0 : $urandom_range(0, 20);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ranked_t want;
    ranked_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[RATING_W-1:0], out_tdata[RATING_W+POS_W-1:RATING_W], out_tlast};
      results_seen++;
      if (ranked_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t unexpected result: rating %h pos %0d last %b",
                   $time, got.rating, got.pos, got.last);
      end else begin
        want = ranked_q.pop_front();
        if (got.rating !== want.rating || got.pos !== want.pos || got.last !== want.last
            || out_tdata[OUT_TDATA_W-1:RATING_W+POS_W] !== '0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t mismatch: expected %h/%0d/%b, got %h/%0d/%b pad %b",
                     $time, want.rating, want.pos, want.last, got.rating, got.pos, got.last,
                     out_tdata[OUT_TDATA_W-1:RATING_W+POS_W]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table. Single-entry batches carry their result by hand; the
  // multi-entry ones go through the predictor.
  // --------------------------------------------------------------------------
  initial begin
    dir_tab = '{
      // lone entries: highest, lowest and mid-scale rating
      '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 6'd0, 1'b1}},
      '{16'h0000, 1'b1, 1'b1, '{16'h0000, 6'd0, 1'b1}},
      '{16'h8000, 1'b1, 1'b1, '{16'h8000, 6'd0, 1'b1}},
      // mixed batch with a duplicate and both extremes
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b0, 1'b0, '0},
      '{16'hAAAA, 1'b0, 1'b0, '0},
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'h0000, 1'b1, 1'b0, '0},
      // all equal: load order must survive
      '{16'h1234, 1'b0, 1'b0, '0},
      '{16'h1234, 1'b0, 1'b0, '0},
      '{16'h1234, 1'b1, 1'b0, '0},
      // ascending load: worst case, every pass but the last swaps
      '{16'h0001, 1'b0, 1'b0, '0},
      '{16'h0002, 1'b0, 1'b0, '0},
      '{16'h0003, 1'b0, 1'b0, '0},
      '{16'h0004, 1'b1, 1'b0, '0},
      // already descending: one clean pass
      '{16'hF000, 1'b0, 1'b0, '0},
      '{16'h0F00, 1'b0, 1'b0, '0},
      '{16'h00F0, 1'b1, 1'b0, '0}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  n;
    int  k;
    int  mode;
    int  rand_sent;
    bit  did_overflow;
    bit  big;
    logic [RATING_W-1:0] r;

    rand_sent    = 0;
    did_overflow = 1'b0;
    items_sent     = 0;
    batches_closed = 0;
    batch_len      = 0;
    calm           = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++)
      send_rating(dir_tab[k].rating, dir_tab[k].last, dir_tab[k].typed, dir_tab[k].res);

    // Pause the sender until the directed results are all out
    drain_results();

    // Random batches: mostly short ones, one that overruns capacity and is
    // closed by a dropped request, and the odd medium batch
    while (rand_sent < RAND_ITEMS) begin
      big = 1'b0;
      if (!did_overflow && rand_sent >= OVERFLOW_AT) begin
        n            = MAX_ENTRIES + 2;
        big          = 1'b1;
        did_overflow = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(9, 20);
      end else begin
        n = $urandom_range(1, 8);
      end
      mode = big ? MODE_WIDE : $urandom_range(MODE_WIDE, MODE_EDGES);
      for (k = 0; k < n; k++) begin
        case (mode)
          MODE_TIES: r = RATING_W'($urandom_range(0, 3));
          MODE_EDGES: begin
            case ($urandom_range(0, 3))
              0:       r = 16'h0000;
              1:       r = 16'hFFFF;
              2:       r = 16'h7FFF;
              default: r = 16'h8000;
            endcase
          end
          default: r = RATING_W'($urandom_range(0, 65535));
        endcase
        send_rating(r, (k == n - 1), 1'b0, '0);
        rand_sent++;
      end
      if (big)
        drain_results();
      calm = (rand_sent >= CALM_FROM);
    end

    // Wind down: everything out, then a little extra for stray results
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests in %0d batches (one over capacity), %0d results checked",
             items_sent, batches_closed, results_seen);
    $display("directed corner batches, random batches with ties and extremes, random stalls");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rsd_pkg.sv
rtl/core/rsd_store.sv
rtl/core/rsd_cmp_unit.sv
rtl/core/rating_sort_descending_core.sv
rtl/core/rsd_checker.sv
tb/sv/tb.sv
